// ----- hw/rtl/csschk_pkg.sv -----
// shared types, constants and codes for the client session sequence checker
// no dependencies; every other file of the block but csschk_ram imports this package
package csschk_pkg;

  // default number of client entries
  localparam int unsigned MaxClientsDef = 256;

  // field widths
  localparam int unsigned FuncW   = 2;
  localparam int unsigned SockW   = 16;
  localparam int unsigned CidW    = 32;
  localparam int unsigned TypeW   = 8;
  localparam int unsigned SeqW    = 64;
  localparam int unsigned TimeW   = 63;
  localparam int unsigned StatW   = 3;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 8;

  // configuration register reset values
  localparam logic [TypeW-1:0] TypeNewRst    = 8'd1;
  localparam logic [TypeW-1:0] TypeCancelRst = 8'd2;

  // event kinds
  typedef enum logic [FuncW-1:0] {
    FUNC_REQUEST  = 2'd0,
    FUNC_RESPONSE = 2'd1,
    FUNC_CLOSE    = 2'd2,
    FUNC_NONE     = 2'd3
  } func_e;

  // result status codes
  typedef enum logic [StatW-1:0] {
    STAT_OK            = 3'd0,
    STAT_BAD_TYPE      = 3'd1,
    STAT_BAD_CLIENT    = 3'd2,
    STAT_SOCK_MISMATCH = 3'd3,
    STAT_SEQ_GAP       = 3'd4,
    STAT_UNROUTABLE    = 3'd5
  } status_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TYPE_NEW    = 1'd0,
    CFG_TYPE_CANCEL = 1'd1
  } cfg_idx_e;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_SWEEP,
    ST_CLOSE
  } state_e;

  // one client entry of the session table
  typedef struct packed {
    logic             bound;
    logic [SockW-1:0] socket;
    logic [SeqW-1:0]  exp_seq;
    logic [SeqW-1:0]  out_seq;
  } row_t;

  localparam int unsigned RowW = $bits(row_t);

  // value of an entry after reset; a close writes it too, but keeps the socket field
  localparam row_t RowInit = '{
    bound:   1'b0,
    socket:  '0,
    exp_seq: 64'd1,
    out_seq: 64'd1
  };

  // controller to datapath commands
  typedef struct packed {
    logic clear_step;
    logic capture;
    logic lookup_commit;
    logic sweep_step;
    logic close_emit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_last;
    logic sweep_done;
    logic out_free;
  } sts_t;

endpackage

// ----- hw/rtl/csschk_if.sv -----
// valid/ready channel interfaces for events in and results out
// depends on csschk_pkg for field widths
interface csschk_in_if import csschk_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [FuncW-1:0] func;
  logic [SockW-1:0] socket_id;
  logic [CidW-1:0]  client_num;
  logic [TypeW-1:0] request_type;
  logic [SeqW-1:0]  seq_num;
  logic [TimeW-1:0] rx_time;

  modport source (output valid, func, socket_id, client_num, request_type, seq_num, rx_time,
                  input ready);
  modport sink (input valid, func, socket_id, client_num, request_type, seq_num, rx_time,
                output ready);
endinterface

interface csschk_out_if import csschk_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [StatW-1:0] status;
  logic [SeqW-1:0]  seq_value;
  logic [TimeW-1:0] forward_time;

  modport source (output valid, status, seq_value, forward_time, input ready);
  modport sink (input valid, status, seq_value, forward_time, output ready);
endinterface

// ----- hw/rtl/csschk_ram.sv -----
// generic single write port, single read port ram with registered read
// no package dependencies
module csschk_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/csschk_ctrl.sv -----
// controller state machine: clearing pass, lookup, close sweep, result hand-off
// depends on csschk_pkg for state, command and status types
module csschk_ctrl import csschk_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [FuncW-1:0] in_func_i,
  output logic             in_ready_o,
  input  sts_t             sts_i,
  output cmd_t             cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (func_e'(in_func_i))
            FUNC_REQUEST, FUNC_RESPONSE: state_d = ST_LOOKUP;
            FUNC_CLOSE:                  state_d = ST_SWEEP;
            default:                     state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOOKUP: begin
        if (sts_i.out_free) begin
          cmd_o.lookup_commit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_done) begin
          state_d = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        if (sts_i.out_free) begin
          cmd_o.close_emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // at most one datapath operation per cycle
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command");

  // a result is loaded only into a free output slot
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.lookup_commit || cmd_o.close_emit) |-> sts_i.out_free)
    else $error("result loaded over a pending one");
`endif

endmodule

// ----- hw/rtl/csschk_dp.sv -----
// datapath: config registers, item register, session table, sweep pointer,
// per-event checks and output register; depends on csschk_pkg and csschk_ram
module csschk_dp import csschk_pkg::*; #(
  parameter int unsigned MaxClients = MaxClientsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration writes
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  // event fields
  input  logic [FuncW-1:0]   in_func_i,
  input  logic [SockW-1:0]   in_socket_id_i,
  input  logic [CidW-1:0]    in_client_num_i,
  input  logic [TypeW-1:0]   in_request_type_i,
  input  logic [SeqW-1:0]    in_seq_num_i,
  input  logic [TimeW-1:0]   in_rx_time_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [StatW-1:0]   out_status_o,
  output logic [SeqW-1:0]    out_seq_value_o,
  output logic [TimeW-1:0]   out_forward_time_o,
  // controller link
  input  cmd_t               cmd_i,
  output sts_t               sts_o
);

  localparam int unsigned AddrW = (MaxClients > 1) ? $clog2(MaxClients) : 1;
  localparam int unsigned PtrW  = $clog2(MaxClients + 1);

  // configuration registers
  logic [TypeW-1:0] type_new_q, type_cancel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_new_q    <= TypeNewRst;
      type_cancel_q <= TypeCancelRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TYPE_NEW:    type_new_q    <= cfg_wdata_i;
        CFG_TYPE_CANCEL: type_cancel_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // captured transaction
  func_e            func_q;
  logic [SockW-1:0] sock_q;
  logic [CidW-1:0]  cid_q;
  logic [TypeW-1:0] rtype_q;
  logic [SeqW-1:0]  seq_q;
  logic [TimeW-1:0] rx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= func_e'(in_func_i);
      sock_q  <= in_socket_id_i;
      cid_q   <= in_client_num_i;
      rtype_q <= in_request_type_i;
      seq_q   <= in_seq_num_i;
      rx_q    <= in_rx_time_i;
    end
  end

  // sweep / clear pointer and pending read of the close sweep
  logic [PtrW-1:0]  ptr_q, ptr_d;
  logic             sw_pend_q, sw_pend_d;
  logic [AddrW-1:0] sw_addr_q;
  logic             ptr_end;

  assign ptr_end = (ptr_q == PtrW'(MaxClients));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q     <= '0;
      sw_pend_q <= 1'b0;
    end else begin
      ptr_q     <= ptr_d;
      sw_pend_q <= sw_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_step) begin
      sw_addr_q <= ptr_q[AddrW-1:0];
    end
  end

  always_comb begin
    ptr_d     = ptr_q;
    sw_pend_d = sw_pend_q;
    if (cmd_i.clear_step) begin
      ptr_d = ptr_q + PtrW'(1);
    end else if (cmd_i.capture) begin
      ptr_d     = '0;
      sw_pend_d = 1'b0;
    end else if (cmd_i.sweep_step) begin
      sw_pend_d = !ptr_end;
      if (!ptr_end) begin
        ptr_d = ptr_q + PtrW'(1);
      end
    end
  end

  // session table
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  row_t             ram_wdata, ram_rdata;

  csschk_ram #(
    .Width (RowW),
    .Depth (MaxClients)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // request and response checks on the fetched entry
  logic             type_ok, in_range, lk_we;
  logic [SockW-1:0] sock_eff;
  row_t             lk_row;
  status_e          lk_stat;
  logic [SeqW-1:0]  lk_seq;
  logic [TimeW-1:0] lk_time;

  assign type_ok  = (rtype_q == type_new_q) || (rtype_q == type_cancel_q);
  assign in_range = (cid_q < CidW'(MaxClients));
  assign sock_eff = ram_rdata.bound ? ram_rdata.socket : sock_q;

  always_comb begin
    lk_we   = 1'b0;
    lk_row  = ram_rdata;
    lk_stat = STAT_OK;
    lk_seq  = '0;
    lk_time = '0;
    case (func_q)
      FUNC_REQUEST: begin
        if (!type_ok) begin
          lk_stat = STAT_BAD_TYPE;
        end else if (!in_range) begin
          lk_stat = STAT_BAD_CLIENT;
        end else begin
          // binding is kept even when a later check fails
          lk_we        = 1'b1;
          lk_row.bound = 1'b1;
          lk_row.socket = sock_eff;
          if (sock_eff != sock_q) begin
            lk_stat = STAT_SOCK_MISMATCH;
          end else if (seq_q != ram_rdata.exp_seq) begin
            lk_stat = STAT_SEQ_GAP;
          end else begin
            lk_row.exp_seq = ram_rdata.exp_seq + SeqW'(1);
            lk_seq  = seq_q;
            lk_time = rx_q;
          end
        end
      end
      FUNC_RESPONSE: begin
        if (!in_range || !ram_rdata.bound) begin
          lk_stat = STAT_UNROUTABLE;
        end else begin
          lk_we          = 1'b1;
          lk_row.out_seq = ram_rdata.out_seq + SeqW'(1);
          lk_seq         = ram_rdata.out_seq;
        end
      end
      default: ;
    endcase
  end

  // table port selection
  logic sw_match;
  row_t sw_row;

  assign sw_match = sw_pend_q && ram_rdata.bound && (ram_rdata.socket == sock_q);

  always_comb begin
    sw_row        = RowInit;
    sw_row.socket = ram_rdata.socket;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cid_q[AddrW-1:0];
    ram_wdata = lk_row;
    ram_re    = 1'b0;
    ram_raddr = in_client_num_i[AddrW-1:0];
    if (cmd_i.clear_step) begin
      ram_we    = 1'b1;
      ram_waddr = ptr_q[AddrW-1:0];
      ram_wdata = RowInit;
    end else if (cmd_i.capture) begin
      ram_re = 1'b1;
    end else if (cmd_i.lookup_commit) begin
      ram_we = lk_we;
    end else if (cmd_i.sweep_step) begin
      ram_we    = sw_match;
      ram_waddr = sw_addr_q;
      ram_wdata = sw_row;
      ram_re    = !ptr_end;
      ram_raddr = ptr_q[AddrW-1:0];
    end
  end

  // output register
  logic             out_vld_q;
  status_e          stat_q;
  logic [SeqW-1:0]  oseq_q;
  logic [TimeW-1:0] otime_q;
  logic             out_load;

  assign out_load = cmd_i.lookup_commit || cmd_i.close_emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup_commit) begin
      stat_q  <= lk_stat;
      oseq_q  <= lk_seq;
      otime_q <= lk_time;
    end else if (cmd_i.close_emit) begin
      stat_q  <= STAT_OK;
      oseq_q  <= '0;
      otime_q <= '0;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign out_status_o       = stat_q;
  assign out_seq_value_o    = oseq_q;
  assign out_forward_time_o = otime_q;

  // status to controller
  assign sts_o.clear_last = (ptr_q == PtrW'(MaxClients - 1));
  assign sts_o.sweep_done = ptr_end;
  assign sts_o.out_free   = !out_vld_q || out_ready_i;

`ifndef SYNTHESIS
  // table writes stay inside the configured client range
  a_waddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (32'(ram_waddr) < MaxClients))
    else $error("table write outside client range");
`endif

endmodule

// ----- hw/rtl/client_session_sequence_checker.sv -----
// Client session sequence checker, top level: joins controller, datapath and interfaces.
// Depends on csschk_pkg, csschk_if, csschk_ctrl, csschk_dp (and csschk_ram below it).
//
// Usage:
//  - in_i carries one event per transaction: a client request, an outgoing
//    response or a connection close; out_o returns one result per request,
//    response or close. Event kind 3 is taken and dropped without a result.
//  - cfg_we_i/cfg_idx_i/cfg_wdata_i write the two accepted request type codes;
//    writes are taken at any time, but are meant for an idle block.
//  - One event is in work at a time. A request or response reads its client
//    entry from the session table and writes it back: the result is loaded
//    once the output register is free, and the next event is accepted only
//    after the result is loaded.
//  - A close sweeps every table entry through the single table read port; its
//    result is loaded once the sweep is done and the output register is free.
//  - After reset a clearing pass writes every table entry with in_i.ready low;
//    configuration writes are taken meanwhile.
//  - The result sits in an output register; while the receiver stalls, the
//    block still accepts the next event and finishes its lookup, then holds
//    it until the output register frees up.
module client_session_sequence_checker import csschk_pkg::*; #(
  parameter int unsigned MaxClients = MaxClientsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  csschk_in_if.sink          in_i,
  csschk_out_if.source       out_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencing of clear, lookup, sweep and hand-off
  csschk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_func_i  (in_i.func),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // table, checks and result register
  csschk_dp #(
    .MaxClients (MaxClients)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_func_i          (in_i.func),
    .in_socket_id_i     (in_i.socket_id),
    .in_client_num_i    (in_i.client_num),
    .in_request_type_i  (in_i.request_type),
    .in_seq_num_i       (in_i.seq_num),
    .in_rx_time_i       (in_i.rx_time),
    .out_valid_o        (out_o.valid),
    .out_ready_i        (out_o.ready),
    .out_status_o       (out_o.status),
    .out_seq_value_o    (out_o.seq_value),
    .out_forward_time_o (out_o.forward_time),
    .cmd_i              (cmd),
    .sts_o              (sts)
  );

`ifndef SYNTHESIS
  // one event at a time: no accept right after an accepted event of a used kind
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && (in_i.func != FUNC_NONE)) |=> !in_i.ready)
    else $error("transaction accepted while previous one in work");
`endif

endmodule
